FILE: rtl/core/vlpd_pkg.sv
// vlpd_pkg: shared types and constants of the length-prefixed message deframer
// no dependencies
`timescale 1ns / 1ps

package vlpd_pkg;

   localparam int MAX_LENGTH_BYTES = 8;
   localparam int LENGTH_WIDTH     = 32;
   localparam int MAX_LEN_WIDTH    = 32;
   localparam int CMP_WIDTH        = (LENGTH_WIDTH > MAX_LEN_WIDTH) ? LENGTH_WIDTH : MAX_LEN_WIDTH;
   localparam int COUNT_WIDTH      = 4;
   localparam int BYTE_WIDTH       = 8;
   localparam int RSP_DATA_WIDTH   = 16;

   localparam logic [MAX_LEN_WIDTH-1:0] MAX_LEN_RESET = MAX_LEN_WIDTH'(65536);
   localparam logic [3:0] NEG_NIBBLE = 4'hF;

   typedef enum logic [1:0] {
      ERR_NEG_ZERO  = 2'd0,
      ERR_TOO_MANY  = 2'd1,
      ERR_NOT_POS   = 2'd2,
      ERR_TOO_LONG  = 2'd3
   } err_code_type;

   typedef struct packed {
      logic                  is_error;
      logic [BYTE_WIDTH-1:0] payload_byte;
      logic                  first_of_message;
      logic                  last_of_message;
      err_code_type          err_kind;
   } rsp_type;

endpackage

FILE: rtl/core/vlpd_in_reg.sv
// vlpd_in_reg: input register stage in front of the deframer state logic
// depends on vlpd_pkg
`timescale 1ns / 1ps

module vlpd_in_reg (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [vlpd_pkg::BYTE_WIDTH-1:0] req_tdata,
   input  logic                           consume,
   output logic                           byte_valid,
   output logic [vlpd_pkg::BYTE_WIDTH-1:0] byte_data
);
   import vlpd_pkg::*;

   logic                  valid_ff, valid_in;
   logic [BYTE_WIDTH-1:0] data_ff, data_in;
   logic                  load;

   assign req_tready = !valid_ff || consume;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_tdata;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;

endmodule

FILE: rtl/core/vlpd_parse.sv
// vlpd_parse: header, length and payload state machine with the length checks
// depends on vlpd_pkg
`timescale 1ns / 1ps

module vlpd_parse (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [vlpd_pkg::MAX_LEN_WIDTH-1:0] csr_wr_data,
   input  logic                              byte_valid,
   input  logic [vlpd_pkg::BYTE_WIDTH-1:0]    byte_data,
   input  logic                              out_free,
   output logic                              consume,
   output logic                              res_valid,
   output vlpd_pkg::rsp_type                 res
);
   import vlpd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LENGTH  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_HALTED  = 2'd3
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]    left_ff, left_in;
   logic                      neg_ff, neg_in;
   logic [LENGTH_WIDTH-1:0]   acc_ff, acc_in;
   logic [MAX_LEN_WIDTH-1:0]  pay_left_ff, pay_left_in;
   logic                      first_ff, first_in;
   logic [MAX_LEN_WIDTH-1:0]  max_len_ff;

   logic                      produce;
   rsp_type                   res_c;
   logic                      hdr_neg;
   logic [BYTE_WIDTH-1:0]     hdr_count;
   logic [LENGTH_WIDTH-1:0]   acc_shift;
   logic [LENGTH_WIDTH-1:0]   len_value;
   logic                      pay_last;

   always_comb begin
      hdr_neg   = (byte_data[7:4] == NEG_NIBBLE);
      hdr_count = hdr_neg ? {4'd0, byte_data[3:0]} : byte_data;
      acc_shift = (acc_ff << BYTE_WIDTH) | LENGTH_WIDTH'(byte_data);
      // two's complement negation when the header flagged a negative length
      len_value = neg_ff ? (~acc_shift + LENGTH_WIDTH'(1)) : acc_shift;
      pay_last  = (pay_left_ff <= MAX_LEN_WIDTH'(1));
   end

   always_comb begin
      phase_in    = phase_ff;
      left_in     = left_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      pay_left_in = pay_left_ff;
      first_in    = first_ff;
      produce     = 1'b0;
      res_c       = '0;
      case (phase_ff)
         PH_HEADER: begin
            neg_in = hdr_neg;
            if (hdr_count == '0) begin
               produce          = 1'b1;
               res_c.is_error   = 1'b1;
               res_c.err_kind   = hdr_neg ? ERR_NEG_ZERO : ERR_NOT_POS;
               phase_in         = PH_HALTED;
            end else if (hdr_count > BYTE_WIDTH'(MAX_LENGTH_BYTES)) begin
               produce          = 1'b1;
               res_c.is_error   = 1'b1;
               res_c.err_kind   = ERR_TOO_MANY;
               phase_in         = PH_HALTED;
            end else begin
               acc_in   = '0;
               left_in  = hdr_count[COUNT_WIDTH-1:0];
               phase_in = PH_LENGTH;
            end
         end
         PH_LENGTH: begin
            acc_in  = acc_shift;
            left_in = left_ff - COUNT_WIDTH'(1);
            if (left_ff == COUNT_WIDTH'(1)) begin
               if (len_value == '0 || len_value[LENGTH_WIDTH-1]) begin
                  produce          = 1'b1;
                  res_c.is_error   = 1'b1;
                  res_c.err_kind   = ERR_NOT_POS;
                  phase_in         = PH_HALTED;
               end else if (CMP_WIDTH'(len_value) > CMP_WIDTH'(max_len_ff)) begin
                  produce          = 1'b1;
                  res_c.is_error   = 1'b1;
                  res_c.err_kind   = ERR_TOO_LONG;
                  phase_in         = PH_HALTED;
               end else begin
                  pay_left_in = MAX_LEN_WIDTH'(len_value);
                  first_in    = 1'b1;
                  phase_in    = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            produce                = 1'b1;
            res_c.payload_byte     = byte_data;
            res_c.first_of_message = first_ff;
            res_c.last_of_message  = pay_last;
            first_in               = 1'b0;
            if (pay_last) begin
               pay_left_in = '0;
               first_in    = 1'b1;
               phase_in    = PH_HEADER;
            end else begin
               pay_left_in = pay_left_ff - MAX_LEN_WIDTH'(1);
            end
         end
         default: begin
            // halted: bytes are taken and dropped
         end
      endcase
   end

   // a byte with no result never waits on the output side
   assign consume   = byte_valid && (!produce || out_free);
   assign res_valid = consume && produce;
   assign res       = res_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         left_ff     <= '0;
         neg_ff      <= 1'b0;
         acc_ff      <= '0;
         pay_left_ff <= '0;
         first_ff    <= 1'b1;
         max_len_ff  <= MAX_LEN_RESET;
      end else begin
         if (consume) begin
            phase_ff    <= phase_in;
            left_ff     <= left_in;
            neg_ff      <= neg_in;
            acc_ff      <= acc_in;
            pay_left_ff <= pay_left_in;
            first_ff    <= first_in;
         end
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

endmodule

FILE: rtl/core/vlpd_out_reg.sv
// vlpd_out_reg: result register that drives the response stream
// depends on vlpd_pkg
`timescale 1ns / 1ps

module vlpd_out_reg (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                res_valid,
   input  vlpd_pkg::rsp_type                   res,
   output logic                                out_free,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [vlpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import vlpd_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type res_ff, res_in;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (res_valid) begin
         valid_in = 1'b1;
         res_in   = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.err_kind, res_ff.first_of_message, res_ff.payload_byte};
   assign rsp_tuser  = res_ff.is_error;
   assign rsp_tlast  = res_ff.last_of_message;

endmodule

FILE: rtl/core/varint_length_prefix_deframer_top.sv
// varint_length_prefix_deframer_top: length-prefixed message deframer, top level
// path: an accepted request byte passes the input register, then the result register that drives rsp_tvalid
// throughput: one byte per cycle while the response side does not stall, set by the single-pass state update
// header and length bytes give no response unless they end in an error
// reset (synchronous, active high) clears both stages, returns to header phase, max length 65536
// depends on vlpd_pkg, vlpd_in_reg, vlpd_parse, vlpd_out_reg
`timescale 1ns / 1ps

module varint_length_prefix_deframer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [vlpd_pkg::MAX_LEN_WIDTH-1:0]  csr_wr_data,   // max_message_length
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vlpd_pkg::BYTE_WIDTH-1:0]     req_tdata,     // [7:0] data_byte
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] payload_byte, [8] first_of_message, [10:9] err_kind, [15:11] zero
   output logic [vlpd_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                                rsp_tuser,     // [0] is_error
   output logic                                rsp_tlast      // last_of_message
);
   import vlpd_pkg::*;

   logic                  consume;
   logic                  byte_valid;
   logic [BYTE_WIDTH-1:0] byte_data;
   logic                  out_free;
   logic                  res_valid;
   rsp_type               res;

   vlpd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .consume    (consume),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   vlpd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data),
      .out_free    (out_free),
      .consume     (consume),
      .res_valid   (res_valid),
      .res         (res)
   );

   vlpd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
